// File: rtl/core/assert_macros.svh
// Assertion macros shared by the dehaze pixel RTL.
// Depends on clk_i and rst_ni being in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DCD_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("dcd assertion failed");

// Next-cycle implication, checked out of reset.
`define DCD_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("dcd assertion failed");

`endif

// File: rtl/core/dcd_pkg.sv
// Types and constants for the dark channel dehaze pixel pipeline.
// No dependencies.
`default_nettype none

package dcd_pkg;

  localparam logic [7:0] T_CLEAR   = 8'd255;  // transmission with no haze
  localparam logic [7:0] T_OPAQUE  = 8'd0;    // transmission clamped from below
  localparam logic [7:0] T_MIN_DIV = 8'd26;   // lowest T that divides; below it t = 0.1

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic [7:0] dark_level;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] transmission;
  } pix_out_t;

  // Item between the transmission and recovery halves.
  typedef struct packed {
    logic [7:0] airlight;
    logic [7:0] transmission;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } trans_t;

endpackage

`default_nettype wire

// File: rtl/core/dark_channel_dehaze_pixel_top.sv
// Top level of the per-pixel dark channel dehaze pipeline.
// Depends on dcd_pkg, dcd_trans and dcd_recover.
// Pipeline: 3 transmission + 3 recovery stages, all registered.
// Throughput: one item per clock; each stage stalls only when full and blocked downstream.
// Reset: stage valid bits clear and airlight returns to 255; payload registers are not reset.
`default_nettype none

module dark_channel_dehaze_pixel_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input pixels
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire dcd_pkg::pix_in_t  in_data_i,
  // recovered pixels
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dcd_pkg::pix_out_t      out_data_o,
  // airlight register write
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i
);

  // Airlight register; to be written only while the pipeline is empty, a rule the block leaves to the user.
  logic [7:0] airlight_d, airlight_q;

  // Link between the two halves.
  logic            mid_valid;
  logic            mid_stall;
  dcd_pkg::trans_t mid_data;

  assign airlight_d = cfg_we_i ? cfg_wdata_i : airlight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      airlight_q <= 8'd255;
    end else begin
      airlight_q <= airlight_d;
    end
  end

  // Derive the transmission byte; each item captures airlight on entry.
  dcd_trans u_trans (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .airlight_i  (airlight_q),
    .out_valid_o (mid_valid),
    .out_stall_i (mid_stall),
    .out_data_o  (mid_data)
  );

  // Invert the haze model for blue and green; red and T ride along.
  dcd_recover u_recover (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_stall_o  (mid_stall),
    .in_data_i   (mid_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/dcd_trans.sv
// Three-stage transmission pipeline: T = floor((1020A - 765D) / 4A), clamped.
// Depends on dcd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dcd_trans (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire dcd_pkg::pix_in_t in_data_i,
  input  wire logic [7:0]      airlight_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output dcd_pkg::trans_t      out_data_o
);

  // Reciprocal table floor(2^16 / A), entry 0 unused.
  logic [16:0] recip_a [256];
  for (genvar g = 0; g < 256; g++) begin : g_recip
    localparam int unsigned RecipVal = 65536 / ((g == 0) ? 1 : g);
    assign recip_a[g] = 17'(RecipVal);
  end

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // Stage 1: numerator.
  logic [17:0] air_x;
  logic [17:0] dark_x;
  logic [17:0] num_diff;
  logic        pos_d;
  logic [15:0] n1_d, n1_q, n2_q;
  logic        pos1_q, pos2_q;
  logic [7:0]  a1_q, a2_q;
  logic [7:0]  b1_q, g1_q, r1_q, b2_q, g2_q, r2_q;

  // Stage 2: reciprocal multiply.
  logic [32:0] prod;
  logic [7:0]  qe_d, qe_q;

  // Stage 3: correction and clamps.
  logic [15:0] qa;
  logic [15:0] rem;
  logic [7:0]  t_corr;
  logic [7:0]  t_d;
  dcd_pkg::trans_t out_q;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  assign air_x    = 18'(airlight_i) * 18'd1020;
  assign dark_x   = 18'(in_data_i.dark_level) * 18'd765;
  assign num_diff = air_x - dark_x;
  assign pos_d    = air_x > dark_x;
  assign n1_d     = pos_d ? num_diff[17:2] : 16'd0;

  assign prod = 33'(n1_q) * 33'(recip_a[a1_q]);
  assign qe_d = prod[23:16];

  assign qa     = 16'(qe_q) * 16'(a2_q);
  assign rem    = n2_q - qa;
  assign t_corr = (rem >= 16'(a2_q)) ? qe_q + 8'd1 : qe_q;

  always_comb begin
    if (a2_q == 8'd0) begin
      t_d = dcd_pkg::T_CLEAR;
    end else if (!pos2_q) begin
      t_d = dcd_pkg::T_OPAQUE;
    end else begin
      t_d = t_corr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      n1_q   <= n1_d;
      pos1_q <= pos_d;
      a1_q   <= airlight_i;
      b1_q   <= in_data_i.blue_in;
      g1_q   <= in_data_i.green_in;
      r1_q   <= in_data_i.red_in;
    end
    if (en2) begin
      qe_q   <= qe_d;
      n2_q   <= n1_q;
      pos2_q <= pos1_q;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      g2_q   <= g1_q;
      r2_q   <= r1_q;
    end
    if (en3) begin
      out_q.airlight     <= a2_q;
      out_q.transmission <= t_d;
      out_q.blue         <= b2_q;
      out_q.green        <= g2_q;
      out_q.red          <= r2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  // Reciprocal estimate is off by at most one.
  `DCD_ASSERT_NOW(a_rem_bound, v2_q && pos2_q, (17'(rem) < {1'b0, a2_q, 1'b0}))
  // Zero airlight always reports a clear transmission.
  `DCD_ASSERT_NOW(a_zero_air, v3_q && out_q.airlight == 8'd0,
                  out_q.transmission == dcd_pkg::T_CLEAR)
  // An item in stage two that may advance lands in stage three.
  `DCD_ASSERT_NEXT(a_advance, v2_q && en3, v3_q)

endmodule

`default_nettype wire

// File: rtl/core/dcd_recover.sv
// Three-stage channel recovery: J = |(I - A)/t + A|, saturated at 255.
// Depends on dcd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dcd_recover (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire dcd_pkg::trans_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output dcd_pkg::pix_out_t     out_data_o
);

  // Reciprocal table floor(2^17 / T); entries below the divide threshold unused.
  logic [12:0] recip_t [256];
  for (genvar g = 0; g < 256; g++) begin : g_recip
    localparam int unsigned RecipVal = 131072 / ((g < 26) ? 26 : g);
    assign recip_t[g] = 13'(RecipVal);
  end

  // Numerator magnitude for one channel.
  function automatic logic [16:0] chan_mag(input logic [7:0] ch, input logic [7:0] air,
                                           input logic signed [17:0] air_t,
                                           input logic low_t);
    logic signed [17:0] diff;
    logic signed [17:0] num;
    diff = $signed({10'd0, ch}) - $signed({10'd0, air});
    if (low_t) begin
      num = diff * 18'sd10 + $signed({10'd0, air});
    end else begin
      num = diff * 18'sd255 + air_t;
    end
    chan_mag = num[17] ? 17'(-num) : 17'(num);
  endfunction

  // Quotient correction and saturation for one channel.
  function automatic logic [7:0] chan_out(input logic [16:0] mag, input logic [12:0] qe,
                                          input logic [7:0] t, input logic low_t);
    logic [20:0] qt;
    logic [20:0] rem;
    logic [16:0] val;
    qt  = 21'(qe) * 21'(t);
    rem = 21'(mag) - qt;
    if (low_t) begin
      val = mag;
    end else if (rem >= 21'(t)) begin
      val = 17'(qe) + 17'd1;
    end else begin
      val = 17'(qe);
    end
    chan_out = (val > 17'd255) ? 8'd255 : val[7:0];
  endfunction

  logic en4, en5, en6;
  logic v4_q, v5_q, v6_q;

  // Stage 4.
  logic               small_d;
  logic [15:0]        at_u;
  logic signed [17:0] at_s;
  logic [16:0]        mag_b4_q, mag_g4_q, mag_b5_q, mag_g5_q;
  logic [7:0]         t4_q, t5_q, r4_q, r5_q;
  logic               small4_q, small5_q;

  // Stage 5.
  logic [29:0] prod_b, prod_g;
  logic [12:0] qe_b5_q, qe_g5_q;

  // Stage 6 check terms.
  logic [20:0] rem_b, rem_g;
  dcd_pkg::pix_out_t out_q;

  assign en6 = !v6_q || !out_stall_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign in_stall_o = !en4;

  assign small_d = in_data_i.transmission < dcd_pkg::T_MIN_DIV;
  assign at_u    = 16'(in_data_i.airlight) * 16'(in_data_i.transmission);
  assign at_s    = $signed({2'b00, at_u});

  assign prod_b = 30'(mag_b4_q) * 30'(recip_t[t4_q]);
  assign prod_g = 30'(mag_g4_q) * 30'(recip_t[t4_q]);

  assign rem_b = 21'(mag_b5_q) - 21'(qe_b5_q) * 21'(t5_q);
  assign rem_g = 21'(mag_g5_q) - 21'(qe_g5_q) * 21'(t5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      mag_b4_q <= chan_mag(in_data_i.blue, in_data_i.airlight, at_s, small_d);
      mag_g4_q <= chan_mag(in_data_i.green, in_data_i.airlight, at_s, small_d);
      t4_q     <= in_data_i.transmission;
      r4_q     <= in_data_i.red;
      small4_q <= small_d;
    end
    if (en5) begin
      qe_b5_q  <= prod_b[29:17];
      qe_g5_q  <= prod_g[29:17];
      mag_b5_q <= mag_b4_q;
      mag_g5_q <= mag_g4_q;
      t5_q     <= t4_q;
      r5_q     <= r4_q;
      small5_q <= small4_q;
    end
    if (en6) begin
      out_q.blue_out     <= chan_out(mag_b5_q, qe_b5_q, t5_q, small5_q);
      out_q.green_out    <= chan_out(mag_g5_q, qe_g5_q, t5_q, small5_q);
      out_q.red_out      <= r5_q;
      out_q.transmission <= t5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = out_q;

  // Reciprocal estimates are off by at most one on both channels.
  `DCD_ASSERT_NOW(a_rem_b, v5_q && !small5_q, (rem_b < {12'd0, t5_q, 1'b0}))
  `DCD_ASSERT_NOW(a_rem_g, v5_q && !small5_q, (rem_g < {12'd0, t5_q, 1'b0}))

endmodule

`default_nettype wire
